FILE: rtl/nmpm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the normalized multi-pattern matcher.
// Holds the UTF-8 lead-byte codes and the fixed pattern ROM; no dependencies.
package nmpm_pkg;

  localparam int PAT_COUNT   = 21;
  localparam int PAT_MAX_LEN = 21;
  localparam int PAT_LEN_W   = $clog2(PAT_MAX_LEN + 1);
  localparam int PAT_VEC_W   = PAT_MAX_LEN * 8;

  // UTF-8 lead byte classes: (byte & MASK) == CODE
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef logic [PAT_VEC_W-1:0] pat_vec_t;

  // One byte moving along the window, with its occupancy bit.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_link_t;

  // Pattern text, newest (last) character in bits [7:0]; bits above the
  // pattern length are zero.
  localparam pat_vec_t PAT_TEXT [PAT_COUNT] = '{
    pat_vec_t'(88'h736f7573746974726167_65),
    pat_vec_t'(64'h616d6172616f7267),
    pat_vec_t'(104'h6d696e6770616f63616e616461),
    pat_vec_t'(64'h6472616d61626179),
    pat_vec_t'(80'h6e6577617369616e7476),
    pat_vec_t'(72'h6d6b7663696e656d61),
    pat_vec_t'(72'h6b69737361736961_6e),
    pat_vec_t'(136'h7468616e6b73666f7277617463_68696e67),
    pat_vec_t'(152'h7468616e6b796f75666f7277617463_68696e67),
    pat_vec_t'(120'h706c65617365737562736372696265),
    pat_vec_t'(168'h737562736372696265746f7468656368616e6e656c),
    pat_vec_t'(104'h6c696b65746869737669646_56f),
    pat_vec_t'(72'he5ad97e5b995e794b1),
    pat_vec_t'(72'he5ad97e5b995e7bb84),
    pat_vec_t'(96'he5ad97e5b995e588b6e4bd9c),
    pat_vec_t'(72'he69cace5ad97e5b995),
    pat_vec_t'(96'he5ad97e5b995e68f90e4be9b),
    pat_vec_t'(96'he8b0a2e8b0a2e8a782e79c8b),
    pat_vec_t'(96'he8b0a2e8b0a2e694b6e79c8b),
    pat_vec_t'(72'he8afb7e8aea2e99885),
    pat_vec_t'(96'he782b9e8b59ee8aea2e99885)
  };

  localparam logic [PAT_LEN_W-1:0] PAT_LEN [PAT_COUNT] = '{
    PAT_LEN_W'(11), PAT_LEN_W'(8),  PAT_LEN_W'(13), PAT_LEN_W'(8),
    PAT_LEN_W'(10), PAT_LEN_W'(9),  PAT_LEN_W'(9),  PAT_LEN_W'(17),
    PAT_LEN_W'(19), PAT_LEN_W'(15), PAT_LEN_W'(21), PAT_LEN_W'(13),
    PAT_LEN_W'(9),  PAT_LEN_W'(9),  PAT_LEN_W'(12), PAT_LEN_W'(9),
    PAT_LEN_W'(12), PAT_LEN_W'(12), PAT_LEN_W'(12), PAT_LEN_W'(9),
    PAT_LEN_W'(12)
  };

endpackage

FILE: rtl/nmpm_norm.sv
`timescale 1ns / 1ps
// Byte normalizer: keeps lower-cased ASCII alphanumerics and whole UTF-8
// sequences. Depends on nmpm_pkg.
module nmpm_norm (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   acc_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   has_byte_i,
  input  logic                   last_i,
  output nmpm_pkg::byte_link_t   push_o
);
  import nmpm_pkg::*;

  logic [1:0] copy_rem_q, copy_rem_d;
  byte_link_t push;

  always_comb begin
    push.vld   = 1'b0;
    push.data  = data_byte_i;
    copy_rem_d = copy_rem_q;
    if (acc_i && has_byte_i) begin
      if (copy_rem_q != 2'd0) begin
        push.vld   = 1'b1;
        copy_rem_d = copy_rem_q - 2'd1;
      end else if (!data_byte_i[7]) begin
        case (data_byte_i) inside
          [8'h30:8'h39], [8'h61:8'h7a]: push.vld = 1'b1;
          [8'h41:8'h5a]: begin
            push.vld  = 1'b1;
            push.data = data_byte_i | CASE_BIT;
          end
          default: push.vld = 1'b0;
        endcase
      end else begin
        push.vld = 1'b1;
        if ((data_byte_i & LEAD2_MASK) == LEAD2_CODE) begin
          copy_rem_d = 2'd1;
        end else if ((data_byte_i & LEAD3_MASK) == LEAD3_CODE) begin
          copy_rem_d = 2'd2;
        end else if ((data_byte_i & LEAD4_MASK) == LEAD4_CODE) begin
          copy_rem_d = 2'd3;
        end else begin
          copy_rem_d = 2'd0;
        end
      end
    end
    // drop any unfinished sequence at the end of the string
    if (acc_i && last_i) begin
      copy_rem_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_rem_q <= 2'd0;
    end else begin
      copy_rem_q <= copy_rem_d;
    end
  end

  assign push_o = push;

endmodule

FILE: rtl/nmpm_cell.sv
`timescale 1ns / 1ps
// One window cell: holds the byte of a fixed age; below age PAT_MAX_LEN it
// also compares it against the pattern ROM at that age. Depends on nmpm_pkg.
module nmpm_cell #(
  parameter int AGE = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  logic                               clear_i,
  input  nmpm_pkg::byte_link_t               link_i,
  output nmpm_pkg::byte_link_t               link_o,
  output logic [nmpm_pkg::PAT_COUNT-1:0]     match_o
);
  import nmpm_pkg::*;

  byte_link_t slot_q, slot_d, shifted;

  assign shifted = shift_i ? link_i : slot_q;

  always_comb begin
    slot_d = shifted;
    if (clear_i) begin
      slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign link_o = slot_q;

  // compare the byte as it stands after this cycle's shift
  if (AGE < PAT_MAX_LEN) begin : g_cmp
    always_comb begin
      for (int p = 0; p < PAT_COUNT; p++) begin
        if (AGE < int'(PAT_LEN[p])) begin
          match_o[p] = shifted.vld && (shifted.data == PAT_TEXT[p][8*AGE +: 8]);
        end else begin
          match_o[p] = 1'b1;
        end
      end
    end
  end else begin : g_no_cmp
    assign match_o = '1;
  end

endmodule

FILE: rtl/normalized_multi_pattern_match.sv
`timescale 1ns / 1ps
// Normalized multi-pattern matcher, top level. Instantiates nmpm_norm and a
// chain of nmpm_cell; depends on nmpm_pkg.
//
// Takes a UTF-8 string one request per cycle, with no bubbles while stall is
// low: each accepted byte is normalized (ASCII letters lower-cased, ASCII
// digits kept, other ASCII dropped, multi-byte sequences copied whole) and
// shifted into a row of WINDOW_BYTES cells in the same cycle. Every cell of age
// below PAT_MAX_LEN compares its byte against the fixed subtitle-credit pattern
// ROM, and the AND of the cells' compares per pattern sets a sticky found flag.
// A request with last set returns one result, is_boilerplate, through the
// output buffer, and clears the cells, the found flag and the normalizer state
// so the next string may follow. A request with has_byte low carries no byte;
// with last also set it reports the flag (an empty string gives 0). Throughput
// is one request per cycle while stall is low, set by the shift and compare
// across the cell row. Results sit in a two-entry output buffer, and stall is
// raised only while both entries are held.
module normalized_multi_pattern_match #(
  parameter int WINDOW_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_boilerplate_o
);
  import nmpm_pkg::*;

  logic                 in_acc;
  logic                 str_end;
  byte_link_t           push;
  byte_link_t           links [WINDOW_BYTES];
  logic [PAT_COUNT-1:0] cell_match [WINDOW_BYTES];
  logic [PAT_COUNT-1:0] pat_hit;
  logic                 hit;
  logic                 found_q, found_d, found_now;

  logic out_vld_q, out_val_q;
  logic skid_vld_q, skid_val_q;
  logic out_pop;

  // Accept whenever the output buffer has room.
  assign in_acc  = in_valid_i && !in_stall_o;
  assign str_end = in_acc && last_i;

  nmpm_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .push_o      (push)
  );

  // Cell 0 holds the newest byte; each cell hands its byte to the next.
  assign links[0] = push;

  for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_cell
    if (k < WINDOW_BYTES - 1) begin : g_mid
      nmpm_cell #(.AGE(k)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (push.vld),
        .clear_i (str_end),
        .link_i  (links[k]),
        .link_o  (links[k+1]),
        .match_o (cell_match[k])
      );
    end else begin : g_tail
      nmpm_cell #(.AGE(k)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (push.vld),
        .clear_i (str_end),
        .link_i  (links[k]),
        .link_o  (),
        .match_o (cell_match[k])
      );
    end
  end

  // A pattern hits when every cell of its length agrees.
  always_comb begin
    pat_hit = '1;
    for (int k = 0; k < WINDOW_BYTES; k++) begin
      pat_hit = pat_hit & cell_match[k];
    end
  end

  assign hit       = push.vld && (|pat_hit);
  assign found_now = found_q || hit;

  always_comb begin
    found_d = found_now;
    if (str_end) begin
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  // Two-entry output buffer: head register plus skid entry.
  assign out_pop = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_pop) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= str_end;
        end else begin
          out_vld_q  <= str_end;
        end
      end else if (str_end) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_pop) begin
      if (skid_vld_q) begin
        out_val_q  <= skid_val_q;
        skid_val_q <= found_now;
      end else begin
        out_val_q  <= found_now;
      end
    end else if (str_end) begin
      skid_val_q <= found_now;
    end
  end

  assign in_stall_o       = skid_vld_q;
  assign out_valid_o      = out_vld_q;
  assign is_boilerplate_o = out_val_q;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a held head.
  a_skid_behind_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while head empty");

  // End of string clears the flag.
  a_flag_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    str_end |=> !found_q)
    else $error("found flag survived end of string");

  // The flag is sticky within a string.
  a_flag_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && !str_end) |=> found_q)
    else $error("found flag dropped mid-string");

  // A result enters the buffer exactly when a string ends.
  a_result_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (str_end && !out_vld_q) |=> (out_vld_q && (out_val_q == $past(found_now))))
    else $error("result not registered at end of string");
`endif

endmodule

FILE: sim/tb_normalized_multi_pattern_match.sv
`timescale 1ns / 1ps
// Testbench for normalized_multi_pattern_match: drives UTF-8 strings byte by byte
// and checks each end-of-string flag against its own normalize-and-match predictor.
// Depends only on the RTL top level (and its package, through the DUT).
module tb_normalized_multi_pattern_match;

  localparam int WIN          = 32;    // window depth handed to the DUT
  localparam int CLK_HALF     = 6;     // 12 ns clock period
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1600;  // counted requests in the random part
  localparam int DRAIN_CYCLES = 8;     // slack after the last result
  localparam int REPORT_LIMIT = 10;
  localparam int PAT_TOTAL    = 21;
  localparam int PAT_LONGEST  = 21;

  // UTF-8 lead byte classes, (byte & MASK) == CODE
  localparam bit [7:0] ASCII_LIMIT = 8'h80;
  localparam bit [7:0] LEAD2_MASK  = 8'hE0;
  localparam bit [7:0] LEAD2_CODE  = 8'hC0;
  localparam bit [7:0] LEAD3_MASK  = 8'hF0;
  localparam bit [7:0] LEAD3_CODE  = 8'hE0;
  localparam bit [7:0] LEAD4_MASK  = 8'hF8;
  localparam bit [7:0] LEAD4_CODE  = 8'hF0;
  localparam bit [7:0] CONT_CODE   = 8'h80;
  localparam bit [7:0] CASE_FOLD   = 8'h20;

  // Normalizes the accepted bytes of each string, tracks the sticky match flag,
  // and queues the flag that the block must return when the string ends.
  class boilerplate_scoreboard;
    bit [7:0] pat_txt [PAT_TOTAL][PAT_LONGEST];
    int       pat_len [PAT_TOTAL];
    int       pat_loaded;
    bit [7:0] kept_bytes [$];       // newest at the back, at most WIN deep
    int       copy_left;
    bit       found;
    bit       expected_flags [$];
    int       failures;

    function new();
      pat_loaded = 0;
      copy_left  = 0;
      found      = 1'b0;
      failures   = 0;
      add_text("soustitrage");
      add_text("amaraorg");
      add_text("mingpao", "canada");
      add_text("drama", "bay");
      add_text("newasian", "tv");
      add_text("mkv", "cinema");
      add_text("kiss", "asian");
      add_text("thanksforwatching");
      add_text("thankyouforwatching");
      add_text("pleasesubscribe");
      add_text("subscribetothechannel");
      add_text("likethisvideo");
      add_utf8(96'he5ad97e5b995e794b1, 9);
      add_utf8(96'he5ad97e5b995e7bb84, 9);
      add_utf8(96'he5ad97e5b995e588b6e4bd9c, 12);
      add_utf8(96'he69cace5ad97e5b995, 9);
      add_utf8(96'he5ad97e5b995e68f90e4be9b, 12);
      add_utf8(96'he8b0a2e8b0a2e8a782e79c8b, 12);
      add_utf8(96'he8b0a2e8b0a2e694b6e79c8b, 12);
      add_utf8(96'he8afb7e8aea2e99885, 9);
      add_utf8(96'he782b9e8b59ee8aea2e99885, 12);
    endfunction

    function void add_text(string head, string tail = "");
      string full;
      full = {head, tail};
      pat_len[pat_loaded] = full.len();
      for (int i = 0; i < full.len(); i++) pat_txt[pat_loaded][i] = full[i];
      pat_loaded++;
    endfunction

    // First byte of the sequence sits in the highest used byte lane.
    function void add_utf8(bit [95:0] seq, int n);
      pat_len[pat_loaded] = n;
      for (int i = 0; i < n; i++) pat_txt[pat_loaded][i] = seq[8*(n-1-i) +: 8];
      pat_loaded++;
    endfunction

    // Shift one kept byte into the window and compare every pattern against its tail.
    function void shift_in(bit [7:0] b);
      int base;
      bit hit;
      kept_bytes.push_back(b);
      if (kept_bytes.size() > WIN) void'(kept_bytes.pop_front());
      for (int p = 0; p < pat_loaded; p++) begin
        if (pat_len[p] > kept_bytes.size()) continue;
        base = kept_bytes.size() - pat_len[p];
        hit  = 1'b1;
        for (int i = 0; i < pat_len[p]; i++)
          if (kept_bytes[base + i] != pat_txt[p][i]) hit = 1'b0;
        if (hit) found = 1'b1;
      end
    endfunction

    function void normalize(bit [7:0] b);
      if (copy_left != 0) begin
        // inside a multi-byte sequence: copy whatever arrives
        copy_left--;
        shift_in(b);
      end else if (b < ASCII_LIMIT) begin
        if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z")) shift_in(b);
        else if (b >= "A" && b <= "Z") shift_in(b | CASE_FOLD);
      end else begin
        if ((b & LEAD2_MASK) == LEAD2_CODE)      copy_left = 1;
        else if ((b & LEAD3_MASK) == LEAD3_CODE) copy_left = 2;
        else if ((b & LEAD4_MASK) == LEAD4_CODE) copy_left = 3;
        else                                     copy_left = 0;
        shift_in(b);
      end
    endfunction

    function void note_request(bit [7:0] data, bit has, bit ends);
      if (has) normalize(data);
      if (ends) begin
        expected_flags.push_back(found);
        kept_bytes.delete();
        copy_left = 0;
        found     = 1'b0;
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_flags.size() == 0) begin
        if (failures < REPORT_LIMIT)
          $display("%0t: is_boilerplate=%b returned with no string pending", $realtime, got);
        failures++;
        return;
      end
      want = expected_flags.pop_front();
      if (got !== want) begin
        if (failures < REPORT_LIMIT)
          $display("%0t: is_boilerplate expected %b, got %b", $realtime, want, got);
        failures++;
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  typedef struct packed {
    logic [7:0] data;
    logic       has;
  } raw_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       has_byte_i = 1'b0;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       is_boilerplate_o;

  boilerplate_scoreboard sb;
  raw_item_t             line_q [$];   // the string being built, one entry per request
  int                    in_idle_pct = 10;
  int                    out_stall_pct = 75;
  int                    counted_items = 0;

  normalized_multi_pattern_match #(
    .WINDOW_BYTES(WIN)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .has_byte_i      (has_byte_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_boilerplate_o(is_boilerplate_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Stall the result channel at random; the rate follows the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Watch both handshakes: feed accepted requests to the predictor, check results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(data_byte_i, has_byte_i, last_i);
      if (out_valid_o && !out_stall_i) sb.check_result(is_boilerplate_o);
    end
  end

  // Hard limit: far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("normalized_multi_pattern_match verification failed");
    $finish;
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(raw_item_t it, bit ends);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= it.data;
    has_byte_i  <= it.has;
    last_i      <= ends;
    do @(posedge clk_i); while (in_stall_o);
    if (it.has || ends) counted_items++;
  endtask

  // Send the built string; an empty one goes out as a single no-byte request.
  task automatic send_line();
    if (line_q.size() == 0) line_q.push_back('{data: 8'($urandom), has: 1'b0});
    for (int i = 0; i < line_q.size(); i++) send_request(line_q[i], i == line_q.size() - 1);
  endtask

  function automatic void put(bit [7:0] b);
    line_q.push_back('{data: b, has: 1'b1});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  // Append n noise items: letters, digits, punctuation, whole UTF-8
  // characters, raw bytes, and the odd request with no byte.
  function automatic void add_noise(int n);
    bit [7:0] v;
    int       k;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(99) < 5) line_q.push_back('{data: 8'($urandom), has: 1'b0});
      case ($urandom_range(4))
        0: begin
          v = "a" + 8'($urandom_range(25));
          put($urandom_range(1) ? v : (v & ~CASE_FOLD));
        end
        1: put("0" + 8'($urandom_range(9)));
        2: put(8'($urandom_range(127)));
        3: begin
          k = $urandom_range(1, 3);
          case (k)
            1: put(LEAD2_CODE | 8'($urandom_range(31)));
            2: put(LEAD3_CODE | 8'($urandom_range(15)));
            default: put(LEAD4_CODE | 8'($urandom_range(7)));
          endcase
          repeat (k) put(CONT_CODE | 8'($urandom_range(63)));
        end
        default: put(8'($urandom));
      endcase
    end
  endfunction

  // Append one pattern in raw form: random letter case and dropped punctuation
  // for the ASCII ones, separators only between whole characters otherwise,
  // and now and then a near miss with one byte altered.
  function automatic void add_pattern();
    string    seps;
    int       p;
    int       miss_at;
    bit       ascii;
    bit       near_miss;
    bit [7:0] b;
    seps      = " .,-!_'?";
    p         = $urandom_range(PAT_TOTAL - 1);
    ascii     = sb.pat_txt[p][0] < ASCII_LIMIT;
    near_miss = $urandom_range(99) < 15;
    miss_at   = $urandom_range(sb.pat_len[p] - 1);
    for (int i = 0; i < sb.pat_len[p]; i++) begin
      b = sb.pat_txt[p][i];
      if (near_miss && i == miss_at) b = b ^ 8'h01;
      if (ascii && b >= "a" && b <= "z" && $urandom_range(1)) b = b & ~CASE_FOLD;
      put(b);
      if (i < sb.pat_len[p] - 1 && (ascii || i % 3 == 2) && $urandom_range(99) < 20)
        put(seps[$urandom_range(seps.len() - 1)]);
    end
  endfunction

  // Build one random string; most carry a pattern so the flag sees both values.
  function automatic void build_line();
    int cut;
    line_q.delete();
    if ($urandom_range(99) < 3) return;
    add_noise(($urandom_range(99) < 10) ? $urandom_range(30, 70) : $urandom_range(0, 6));
    if ($urandom_range(99) < 65) add_pattern();
    if ($urandom_range(99) < 20) begin
      add_noise($urandom_range(0, 3));
      add_pattern();
    end
    add_noise($urandom_range(0, 4));
    // truncate: end the string mid-pattern or mid-sequence
    if ($urandom_range(99) < 8 && line_q.size() > 0) begin
      cut = $urandom_range(line_q.size() - 1);
      repeat (cut) void'(line_q.pop_back());
    end
    if ($urandom_range(99) < 10) line_q.push_back('{data: 8'($urandom), has: 1'b0});
  endfunction

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty string: a lone no-byte request with last set.
    line_q.delete();
    send_line();

    // Lead bytes copy their continuations verbatim, ASCII included; a stray
    // high byte goes alone; control bytes at both ASCII ends are dropped.
    line_q.delete();
    put(8'hC3); put("A"); put(8'hF0); put("Z"); put(8'h80); put("!");
    put(8'hFF); put(8'h00); put(8'h7F);
    send_line();

    // Mixed case with punctuation and a no-byte request inside still matches.
    line_q.delete();
    put_text("aMaRa-");
    line_q.push_back('{data: 8'hFF, has: 1'b0});
    put_text("OrG");
    send_line();

    // Lone continuation byte, then a sequence cut short by the end of string.
    line_q.delete();
    put(8'h80); put(8'hE5); put(8'hAD);
    send_line();

    // Random part in three phases: slow receiver, slow sender, no idling.
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (counted_items < RANDOM_ITEMS / 3) begin
        in_idle_pct   = 10;
        out_stall_pct = 75;
      end else if (counted_items < 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct   = 75;
        out_stall_pct = 10;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      build_line();
      send_line();
    end

    // Drop valid, let every pending flag come back, then allow a few stray cycles.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("normalized_multi_pattern_match verification clean");
    end else begin
      $display("normalized_multi_pattern_match verification failed");
    end
    $finish;
  end

endmodule

FILE: normalized_multi_pattern_match.f
rtl/nmpm_pkg.sv
rtl/nmpm_norm.sv
rtl/nmpm_cell.sv
rtl/normalized_multi_pattern_match.sv
sim/tb_normalized_multi_pattern_match.sv
